>>> rtl/text_terminal_cursor_buffer_macros.svh
// ----------------------------------------------------------------------------
// text terminal cursor buffer assertion macros
// shared property shorthands for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CURSOR_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_BUFFER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define TTCB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttcb check failed");

// next-cycle implication
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttcb check failed");

`else

`define TTCB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TTCB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/ttcb_pkg.sv
// ----------------------------------------------------------------------------
// ttcb_pkg
// shared constants and types of the text terminal cursor buffer
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

   localparam int MAX_COLS    = 128;
   localparam int MAX_ROWS    = 64;
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int ADDR_W      = COL_W + ROW_W;
   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int CHAR_W      = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // opcodes
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_READ = 1'b1;

   // csr indexes
   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd24;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_ESC      = 8'h1B;
   localparam logic [CHAR_W-1:0] CHAR_DEL      = 8'h7F;
   localparam logic [CHAR_W-1:0] CHAR_NL       = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TILDE    = 8'h7E;
   localparam logic [CHAR_W-1:0] CHAR_UNDER    = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT0   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT3   = 8'h33;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT9   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UP       = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_DOWN     = 8'h42;
   localparam logic [CHAR_W-1:0] CHAR_RIGHT    = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_LEFT     = 8'h44;

   // how the back end forms cell_char
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_SPACE,
      SEL_UNDER,
      SEL_STORE
   } char_sel_type;

   // one classified command from front to back
   typedef struct packed {
      logic                wr_en;
      char_sel_type        char_sel;
      logic [ADDR_W-1:0]   addr;
      logic [CHAR_W-1:0]   wdata;
      logic [COL_W-1:0]    cursor_col;
      logic [ROW_W-1:0]    cursor_row;
      logic                in_escape;
   } cmd_type;

endpackage

`default_nettype wire

>>> rtl/text_terminal_cursor_buffer.sv
// Text terminal cursor buffer: a character grid with a cursor, fed by a byte stream.
// req channel: tuser is the opcode (0 feed a terminal byte, 1 read a displayed cell),
// tdata carries in_byte, read_row and read_col. Every transaction yields exactly one
// rsp transaction with the displayed character (0 for feeds) and the cursor and escape
// status after that item. The grid size comes from the csr port (index 0 columns,
// index 1 rows); csr_ready is always high.
// Throughput is one transaction per cycle unless the rsp side stalls or the store is
// being cleared: the front end updates the cursor and escape parser in the accept
// cycle, and the back end makes at most one access to the character store per cycle.
// An accepted req goes into the command queue, then into the result register.
// A four-entry command queue sits between front and back, and a result register
// holds each response, so a stalled rsp side backs up into the queue and only then
// drops req_tready.
// After reset the store is cleared to spaces by a pass over all 8192 cells, one cell per
// cycle; req_tready stays low until it completes. Cursor, escape parser and grid
// size return to their reset values at once.
// ----------------------------------------------------------------------------
// text_terminal_cursor_buffer
// top level: front end, command queue and back end with the character store
// ----------------------------------------------------------------------------
`default_nettype none

module text_terminal_cursor_buffer (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [23:0]  req_tdata,    // in_byte[7:0], read_row[13:8], read_col[20:14]
   input  wire          req_tuser,    // opcode
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [23:0]  rsp_tdata,    // cell_char[7:0], cursor_col[14:8], cursor_row[20:15],
                                      // in_escape[21]
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire          csr_index,
   input  wire  [7:0]   csr_data
);

   ttcb_pkg::cmd_type  push_cmd;
   ttcb_pkg::cmd_type  head_cmd;
   logic               cmd_push;
   logic               queue_ready;
   logic               head_valid;
   logic               head_pop;
   logic               clear_busy;

   ttcb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_ready (queue_ready),
      .clear_busy  (clear_busy),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   ttcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (push_cmd),
      .push_ready (queue_ready),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .pop_cmd    (head_cmd)
   );

   ttcb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (head_valid),
      .cmd_pop    (head_pop),
      .cmd        (head_cmd),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/ttcb_ram.sv
// ----------------------------------------------------------------------------
// ttcb_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/ttcb_front.sv
// ----------------------------------------------------------------------------
// ttcb_front
// accepts items, runs the escape parser and cursor, classifies store access
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_front (
   input  wire                      clock,
   input  wire                      reset,
   // input stream
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [23:0]              req_tdata,   // in_byte, read_row, read_col
   input  wire                      req_tuser,   // opcode
   // csr write
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire                      csr_index,
   input  wire  [7:0]               csr_data,
   // to queue
   input  wire                      queue_ready,
   input  wire                      clear_busy,
   output logic                     cmd_push,
   output ttcb_pkg::cmd_type        cmd
);

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_SECOND,
      ESC_THIRD,
      ESC_COLLECT
   } esc_state_type;

   localparam int COL_W  = ttcb_pkg::COL_W;
   localparam int ROW_W  = ttcb_pkg::ROW_W;
   localparam int CHAR_W = ttcb_pkg::CHAR_W;

   localparam logic [7:0] GRID_W_MAX = 8'(ttcb_pkg::MAX_COLS);
   localparam logic [6:0] GRID_H_MAX = 7'(ttcb_pkg::MAX_ROWS);

   esc_state_type      esc_ff, esc_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               bracket_ff, bracket_in;
   logic               del_ff, del_in;
   logic [7:0]         columns_ff, columns_in;
   logic [6:0]         rows_ff, rows_in;

   logic               accept;
   logic [CHAR_W-1:0]  in_byte;
   logic [ROW_W-1:0]   read_row;
   logic [COL_W-1:0]   read_col;
   logic [7:0]         grid_w;
   logic [6:0]         grid_h;
   logic               can_left, can_right, can_up, can_down;
   logic [COL_W-1:0]   left_col;
   logic               is_digit;
   logic               read_out;

   assign in_byte  = req_tdata[7:0];
   assign read_row = req_tdata[13:8];
   assign read_col = req_tdata[20:14];

   assign req_tready = queue_ready && !clear_busy;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // effective grid, clamped to 1..max
   always_comb begin
      if (columns_ff == 8'd0) begin
         grid_w = 8'd1;
      end else if (columns_ff > GRID_W_MAX) begin
         grid_w = GRID_W_MAX;
      end else begin
         grid_w = columns_ff;
      end
      if (rows_ff == 7'd0) begin
         grid_h = 7'd1;
      end else if (rows_ff > GRID_H_MAX) begin
         grid_h = GRID_H_MAX;
      end else begin
         grid_h = rows_ff;
      end
   end

   assign can_left  = (col_ff != '0);
   assign can_up    = (row_ff != '0);
   assign can_right = (({1'b0, col_ff} + 8'd1) < grid_w);
   assign can_down  = (({1'b0, row_ff} + 7'd1) < grid_h);
   assign left_col  = can_left ? (col_ff - COL_W'(1)) : col_ff;
   assign is_digit  = (in_byte >= ttcb_pkg::CHAR_DIGIT0) && (in_byte <= ttcb_pkg::CHAR_DIGIT9);
   assign read_out  = ({1'b0, read_row} >= grid_h) || ({1'b0, read_col} >= grid_w);

   always_comb begin
      esc_in        = esc_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      bracket_in    = bracket_ff;
      del_in        = del_ff;
      cmd.wr_en     = 1'b0;
      cmd.char_sel  = ttcb_pkg::SEL_ZERO;
      cmd.addr      = {row_ff, col_ff};
      cmd.wdata     = ttcb_pkg::CHAR_SPACE;

      if (accept) begin
         if (req_tuser == ttcb_pkg::OP_READ) begin
            cmd.addr = {read_row, read_col};
            if (read_out) begin
               cmd.char_sel = ttcb_pkg::SEL_SPACE;
            end else if (read_row == row_ff && read_col == col_ff) begin
               cmd.char_sel = ttcb_pkg::SEL_UNDER;
            end else begin
               cmd.char_sel = ttcb_pkg::SEL_STORE;
            end
         end else begin
            case (esc_ff)
               ESC_SECOND: begin
                  bracket_in = (in_byte == ttcb_pkg::CHAR_LBRACKET);
                  esc_in     = ESC_THIRD;
               end
               ESC_THIRD: begin
                  if (is_digit) begin
                     del_in = bracket_ff && (in_byte == ttcb_pkg::CHAR_DIGIT3);
                     esc_in = ESC_COLLECT;
                  end else begin
                     esc_in = ESC_IDLE;
                     if (bracket_ff) begin
                        if (in_byte == ttcb_pkg::CHAR_UP && can_up) begin
                           row_in = row_ff - ROW_W'(1);
                        end else if (in_byte == ttcb_pkg::CHAR_DOWN && can_down) begin
                           row_in = row_ff + ROW_W'(1);
                        end else if (in_byte == ttcb_pkg::CHAR_RIGHT && can_right) begin
                           col_in = col_ff + COL_W'(1);
                        end else if (in_byte == ttcb_pkg::CHAR_LEFT && can_left) begin
                           col_in = left_col;
                        end
                     end
                  end
               end
               ESC_COLLECT: begin
                  if (in_byte == ttcb_pkg::CHAR_TILDE) begin
                     cmd.wr_en = del_ff;
                     esc_in    = ESC_IDLE;
                  end
                  del_in = 1'b0;
               end
               default: begin
                  if (in_byte == ttcb_pkg::CHAR_ESC) begin
                     esc_in     = ESC_SECOND;
                     bracket_in = 1'b0;
                     del_in     = 1'b0;
                  end else if (in_byte == ttcb_pkg::CHAR_DEL) begin
                     col_in    = left_col;
                     cmd.addr  = {row_ff, left_col};
                     cmd.wr_en = 1'b1;
                  end else if (in_byte == ttcb_pkg::CHAR_NL) begin
                     if (can_down) begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end else begin
                     cmd.wr_en = 1'b1;
                     cmd.wdata = in_byte;
                     if (can_right) begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
               end
            endcase
         end
      end

      cmd.cursor_col = col_in;
      cmd.cursor_row = row_in;
      cmd.in_escape  = (esc_in != ESC_IDLE);
   end

   assign cmd_push = accept;

   always_comb begin
      columns_in = columns_ff;
      rows_in    = rows_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == ttcb_pkg::CSR_COLUMNS) begin
            columns_in = csr_data;
         end else begin
            rows_in = csr_data[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff     <= ESC_IDLE;
         col_ff     <= '0;
         row_ff     <= '0;
         bracket_ff <= 1'b0;
         del_ff     <= 1'b0;
         columns_ff <= ttcb_pkg::COLUMNS_RESET;
         rows_ff    <= ttcb_pkg::ROWS_RESET;
      end else begin
         esc_ff     <= esc_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         bracket_ff <= bracket_in;
         del_ff     <= del_in;
         columns_ff <= columns_in;
         rows_ff    <= rows_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ttcb_queue.sv
// ----------------------------------------------------------------------------
// ttcb_queue
// short command fifo between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_terminal_cursor_buffer_macros.svh"

module ttcb_queue (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  ttcb_pkg::cmd_type        push_cmd,
   output logic                     push_ready,
   output logic                     pop_valid,
   input  wire                      pop,
   output ttcb_pkg::cmd_type        pop_cmd
);

   localparam int DEPTH  = ttcb_pkg::QUEUE_DEPTH;
   localparam int PTR_W  = ttcb_pkg::QPTR_W;
   localparam int CNT_W  = PTR_W + 1;

   ttcb_pkg::cmd_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `TTCB_ASSERT_IMPL(a_no_overflow, clock, reset, push, count_ff != CNT_W'(DEPTH))
   `TTCB_ASSERT_IMPL(a_no_underflow, clock, reset, pop, count_ff != '0)
   `TTCB_ASSERT_NEXT(a_count_step, clock, reset, push && !pop, count_ff == $past(count_ff) + 1)

endmodule

`default_nettype wire

>>> rtl/ttcb_back.sv
// ----------------------------------------------------------------------------
// ttcb_back
// clears the character store, carries out store accesses, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_back (
   input  wire                      clock,
   input  wire                      reset,
   // from queue
   input  wire                      cmd_valid,
   output logic                     cmd_pop,
   input  ttcb_pkg::cmd_type        cmd,
   output logic                     clear_busy,
   // result stream
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [23:0]              rsp_tdata    // cell_char, cursor_col, cursor_row, in_escape
);

   localparam int ADDR_W = ttcb_pkg::ADDR_W;
   localparam int COL_W  = ttcb_pkg::COL_W;
   localparam int ROW_W  = ttcb_pkg::ROW_W;
   localparam int CHAR_W = ttcb_pkg::CHAR_W;

   logic [ADDR_W:0]         clear_cnt_ff, clear_cnt_in;
   logic                    out_valid_ff, out_valid_in;
   ttcb_pkg::char_sel_type  out_sel_ff;
   logic [COL_W-1:0]        out_col_ff;
   logic [ROW_W-1:0]        out_row_ff;
   logic                    out_esc_ff;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [CHAR_W-1:0]       ram_wr_data;
   logic                    ram_rd_en;
   logic [CHAR_W-1:0]       ram_rd_data;
   logic [CHAR_W-1:0]       cell_char;

   // clearing pass runs until the counter reaches the store depth
   assign clear_busy   = !clear_cnt_ff[ADDR_W];
   assign clear_cnt_in = clear_busy ? clear_cnt_ff + (ADDR_W+1)'(1) : clear_cnt_ff;

   assign cmd_pop = cmd_valid && !clear_busy && (!out_valid_ff || rsp_tready);

   always_comb begin
      if (clear_busy) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff[ADDR_W-1:0];
         ram_wr_data = ttcb_pkg::CHAR_SPACE;
      end else begin
         ram_wr_en   = cmd_pop && cmd.wr_en;
         ram_wr_addr = cmd.addr;
         ram_wr_data = cmd.wdata;
      end
   end

   // read data stays put while the result waits
   assign ram_rd_en = cmd_pop && !cmd.wr_en && (cmd.char_sel == ttcb_pkg::SEL_STORE);

   ttcb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (ttcb_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (cmd.addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (cmd_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_sel_ff <= cmd.char_sel;
         out_col_ff <= cmd.cursor_col;
         out_row_ff <= cmd.cursor_row;
         out_esc_ff <= cmd.in_escape;
      end
   end

   always_comb begin
      case (out_sel_ff)
         ttcb_pkg::SEL_SPACE: cell_char = ttcb_pkg::CHAR_SPACE;
         ttcb_pkg::SEL_UNDER: cell_char = ttcb_pkg::CHAR_UNDER;
         ttcb_pkg::SEL_STORE: cell_char = ram_rd_data;
         default:             cell_char = '0;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_esc_ff, out_row_ff, out_col_ff, cell_char};

endmodule

`default_nettype wire
